FILE: src/ppsetb_pkg.sv
// Package for the PPS event timestamp buffer: opcode and record-kind codes,
// and the packed beat types of the capture and record channels. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppsetb_pkg;

	localparam logic OP_EVENT    = 1'b0;
	localparam logic OP_PPS      = 1'b1;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_EVENT  = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [31:0] capture_value;
	} cap_t;

	typedef struct packed {
		logic        record_kind;
		logic [31:0] event_time;
		logic [31:0] pps_time;
		logic [31:0] event_number;
		logic        overflowed;
		logic        last;
	} rec_t;

endpackage
`default_nettype wire

FILE: src/ppsetb_store.sv
// Event slot memory: one write port, one read port with registered read data.
// Uses no package.
`timescale 1ns / 1ps
`default_nettype none
module ppsetb_store #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [31:0]       wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [31:0]       rd_data
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold the read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: src/ppsetb_outreg.sv
// Record output register: holds one beat until the consumer takes it.
// Depends on ppsetb_pkg for the record type.
`timescale 1ns / 1ps
`default_nettype none
module ppsetb_outreg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire ppsetb_pkg::rec_t   load_data,
	output logic                    free,
	output logic                    rec_valid,
	input  wire logic               rec_stall,
	output ppsetb_pkg::rec_t        rec
);

	logic valid_q;
	ppsetb_pkg::rec_t data_q;

	assign free      = !valid_q || !rec_stall;
	assign rec_valid = valid_q;
	assign rec       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!rec_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule
`default_nettype wire

FILE: src/pps_event_timestamp_buffer.sv
// PPS event timestamp buffer top level: control sequencer over the slot memory
// and the record output register. Depends on ppsetb_pkg, ppsetb_store, ppsetb_outreg.
//
//   channel | dir | beat type        | handshake
//   --------+-----+------------------+---------------------------------
//   cap     | in  | ppsetb_pkg::cap_t | cap_valid / cap_stall
//   rec     | out | ppsetb_pkg::rec_t | rec_valid / rec_stall
//
// An event beat is written into the slot memory as it is accepted, if armed and a slot
// is left. For n stored events a PPS beat is accepted, then the header record goes out,
// then one record per cycle while rec is not stalled, paced by the single read port.
// Rec stalls hold the sequencer in place; cap is stalled until the readout ends.
// Reset clears control state only; slot contents need no clearing, as only slots
// filled since the last readout are ever read.
`timescale 1ns / 1ps
`default_nettype none
module pps_event_timestamp_buffer #(
	parameter int EVENT_SLOTS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cap_valid,
	output logic                  cap_stall,
	input  wire ppsetb_pkg::cap_t cap,
	output logic                  rec_valid,
	input  wire logic             rec_stall,
	output ppsetb_pkg::rec_t      rec
);

	localparam int CNT_W = $clog2(EVENT_SLOTS + 1);
	localparam int IDX_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HDR,
		S_EMIT
	} state_t;

	state_t           state_q;
	logic             armed_q;
	logic [CNT_W-1:0] count_q;   // filled slots
	logic [CNT_W-1:0] n_q;       // slots being read out
	logic [CNT_W-1:0] k_q;       // slot position of the next record
	logic [31:0]      total_q;
	logic             drop_q;
	logic [31:0]      pps_q;

	logic             accept;
	logic             wr_en;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [31:0]      rd_data;
	logic [CNT_W-1:0] k_dec;
	logic             free;
	logic             load;
	ppsetb_pkg::rec_t load_data;

	assign cap_stall = (state_q != S_IDLE);
	assign accept    = cap_valid && !cap_stall;
	assign k_dec     = k_q - CNT_W'(1);

	// store an event when armed and a slot is left
	assign wr_en = accept && (cap.opcode == ppsetb_pkg::OP_EVENT) && armed_q
		&& (count_q < CNT_W'(EVENT_SLOTS));

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = '0;
		load      = 1'b0;
		load_data = '0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_HDR: begin
				load                   = free;
				load_data.record_kind  = ppsetb_pkg::KIND_HEADER;
				load_data.event_time   = '0;
				load_data.pps_time     = pps_q;
				load_data.event_number = total_q;
				load_data.overflowed   = drop_q;
				load_data.last         = (n_q == '0);
				// fetch the newest slot
				rd_en   = free && (n_q != '0);
				rd_addr = IDX_W'(n_q - CNT_W'(1));
			end
			S_EMIT: begin
				load                   = free;
				load_data.record_kind  = ppsetb_pkg::KIND_EVENT;
				load_data.event_time   = rd_data;
				load_data.pps_time     = pps_q;
				load_data.event_number = total_q + 32'(k_q);
				load_data.overflowed   = drop_q;
				load_data.last         = (k_q == CNT_W'(1));
				// fetch the next older slot
				rd_en   = free && (k_q != CNT_W'(1));
				rd_addr = IDX_W'(k_dec - CNT_W'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			armed_q <= 1'b0;
			count_q <= '0;
			n_q     <= '0;
			k_q     <= '0;
			total_q <= '0;
			drop_q  <= 1'b0;
			pps_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cap.opcode == ppsetb_pkg::OP_PPS) begin
							armed_q <= 1'b1;
							pps_q   <= cap.capture_value;
							n_q     <= count_q;
							k_q     <= count_q;
							state_q <= S_HDR;
						end else if (wr_en) begin
							count_q <= count_q + CNT_W'(1);
						end else if (armed_q) begin
							drop_q <= 1'b1;
						end
					end
				end
				S_HDR: begin
					if (free) begin
						if (n_q == '0) begin
							count_q <= '0;
							drop_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (free) begin
						if (k_q == CNT_W'(1)) begin
							// close the second: advance the total, empty the store
							total_q <= total_q + 32'(n_q);
							count_q <= '0;
							drop_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							k_q <= k_dec;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	ppsetb_store #(
		.DEPTH  (EVENT_SLOTS),
		.ADDR_W (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (IDX_W'(count_q)),
		.wr_data (cap.capture_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ppsetb_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.load_data (load_data),
		.free      (free),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec       (rec)
	);

endmodule
`default_nettype wire
